// ----- rtl/smha_pkg.sv -----
// shared types, constants and address decode helpers for the segmented memory
package smha_pkg;

  localparam int unsigned TEXT_BYTES  = 65536;
  localparam int unsigned DATA_BYTES  = 65536;
  localparam int unsigned HEAP_BYTES  = 65536;
  localparam int unsigned STACK_BYTES = 65536;
  localparam logic [31:0] HEAP_BASE   = 32'h1004_0000;
  localparam logic [31:0] STACK_TOP   = 32'h7fff_ffff;

  localparam logic [31:0] TEXT_BASE_RST = 32'h0040_0000;
  localparam logic [31:0] TEXT_LAST_RST = 32'h0040_ffff;
  localparam logic [31:0] DATA_BASE_RST = 32'h1000_0000;
  localparam logic [31:0] DATA_LAST_RST = 32'h1000_ffff;

  localparam int unsigned MAX_TD = (TEXT_BYTES > DATA_BYTES) ? TEXT_BYTES : DATA_BYTES;
  localparam int unsigned MAX_HS = (HEAP_BYTES > STACK_BYTES) ? HEAP_BYTES : STACK_BYTES;
  localparam int unsigned MAX_BYTES = (MAX_TD > MAX_HS) ? MAX_TD : MAX_HS;
  localparam int unsigned ROW_W = $clog2((MAX_BYTES + 3) / 4);
  localparam int unsigned OFF_W = ROW_W + 2;
  localparam int unsigned RAM_AW = ROW_W + 2;
  localparam int unsigned RAM_DEPTH = 4 * (2 ** ROW_W);
  localparam int unsigned LANES = 4;

  localparam longint unsigned STACK_END = longint'(STACK_TOP) + 1;
  localparam longint unsigned STACK_LO_L =
      (STACK_END >= STACK_BYTES) ? (STACK_END - STACK_BYTES) : 0;
  localparam logic [32:0] STACK_LO = 33'(STACK_LO_L);
  localparam logic [33:0] HEAP_END = {2'b00, HEAP_BASE} + 34'(HEAP_BYTES);

  localparam int unsigned CFG_AW = 4;
  localparam logic [1:0] REG_TEXT_BASE = 2'd0;
  localparam logic [1:0] REG_TEXT_LAST = 2'd1;
  localparam logic [1:0] REG_DATA_BASE = 2'd2;
  localparam logic [1:0] REG_DATA_LAST = 2'd3;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_ALLOC = 2'd2;

  localparam logic [1:0] SIZE_BAD = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SIZE  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [1:0] SEG_DATA  = 2'd0;
  localparam logic [1:0] SEG_HEAP  = 2'd1;
  localparam logic [1:0] SEG_STACK = 2'd2;
  localparam logic [1:0] SEG_TEXT  = 2'd3;

  typedef enum logic [2:0] {
    FSM_IDLE = 3'b001,
    FSM_EXEC = 3'b010,
    FSM_FIN  = 3'b100
  } fsm_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  access_size;
    logic [31:0] addr;
    logic [31:0] write_data;
    logic [31:0] alloc_bytes;
  } in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [31:0] alloc_addr;
    logic [1:0]  status;
  } out_t;

  typedef struct packed {
    logic             hit;
    logic             fit;
    logic [OFF_W-1:0] off;
  } seg_hit_t;

  function automatic seg_hit_t seg_fit(logic [31:0] a, logic [1:0] nm1, logic [32:0] lo,
                                       logic [32:0] hi, logic [32:0] bytes);
    logic [33:0] top;
    logic [33:0] hi_c;
    logic [33:0] last;
    logic [33:0] diff;
    seg_hit_t    r;
    top  = {1'b0, lo} + {1'b0, bytes} - 34'd1;
    hi_c = ({1'b0, hi} > top) ? top : {1'b0, hi};
    last = {2'b00, a} + {32'd0, nm1};
    diff = {2'b00, a} - {1'b0, lo};
    r.hit = (hi >= lo) && ({1'b0, a} >= lo) && ({2'b00, a} <= hi_c);
    r.fit = (last <= hi_c);
    r.off = diff[OFF_W-1:0];
    return r;
  endfunction

endpackage

// ----- rtl/segmented_memory_with_heap_alloc.sv -----
// top level: segmented byte memory with bump heap allocator and apb config
//
// usage: one request word enters on in_valid_i/in_ready_o (read, write or heap
// allocate) and exactly one result word leaves on out_valid_o/out_ready_i.
// the four segments (data, heap, stack, text) share four byte-lane rams, one per
// value of the two low segment offset bits, so an unaligned access of up to four
// bytes is a single ram access. an item moves through three steps: accept, decode
// plus ram access, result load. a request is taken only in idle, after the last
// result is loaded; that result sits in an output register, so the next word is
// taken while it waits; a stalled receiver holds the following item in its final
// state until the register frees up. reset restores control state, the config
// registers and the heap top; store contents stay undefined until written, no
// clearing pass. segment bounds for text and data are set over the apb port; the
// user must write them only while idle, the block itself does not enforce this.
module segmented_memory_with_heap_alloc (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  smha_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output smha_pkg::out_t                out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [smha_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  smha_pkg::fsm_e state_q, state_d;
  smha_pkg::in_t  in_q;
  smha_pkg::out_t out_q, out_d;
  logic           out_valid_q, out_valid_d;

  logic [31:0] text_base_q, text_last_q, data_base_q, data_last_q;
  logic [31:0] heap_top_q, heap_top_d;

  logic [1:0] status_q, status_d;
  logic [31:0] grant_q, grant_d;
  logic        rd_q, rd_d;
  logic [1:0]  off_lo_q, off_lo_d;
  logic [1:0]  nm1_q, nm1_d;

  logic [1:0]                   nm1;
  smha_pkg::seg_hit_t           hit_data, hit_heap, hit_stack, hit_text;
  logic                         heap_live;
  logic                         dec_ok;
  logic [1:0]                   dec_seg;
  logic [smha_pkg::OFF_W-1:0]   dec_off;
  logic                         mem_go;
  logic [32:0]                  aligned;
  logic [33:0]                  next_top;
  logic                         alloc_ok;
  logic                         exec;
  logic                         cfg_we;

  logic                         lane_we    [smha_pkg::LANES];
  logic                         lane_re    [smha_pkg::LANES];
  logic [smha_pkg::RAM_AW-1:0]  lane_addr  [smha_pkg::LANES];
  logic [7:0]                   lane_wdata [smha_pkg::LANES];
  logic [7:0]                   lane_rdata [smha_pkg::LANES];
  logic [31:0]                  rd_word;

  assign exec = (state_q == smha_pkg::FSM_EXEC);
  assign nm1  = {in_q.access_size[1], in_q.access_size[1] | in_q.access_size[0]};

  // config port
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_comb begin
    unique case (paddr[3:2])
      smha_pkg::REG_TEXT_BASE: prdata = text_base_q;
      smha_pkg::REG_TEXT_LAST: prdata = text_last_q;
      smha_pkg::REG_DATA_BASE: prdata = data_base_q;
      smha_pkg::REG_DATA_LAST: prdata = data_last_q;
      default:                 prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_base_q <= smha_pkg::TEXT_BASE_RST;
      text_last_q <= smha_pkg::TEXT_LAST_RST;
      data_base_q <= smha_pkg::DATA_BASE_RST;
      data_last_q <= smha_pkg::DATA_LAST_RST;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        smha_pkg::REG_TEXT_BASE: text_base_q <= pwdata;
        smha_pkg::REG_TEXT_LAST: text_last_q <= pwdata;
        smha_pkg::REG_DATA_BASE: data_base_q <= pwdata;
        smha_pkg::REG_DATA_LAST: data_last_q <= pwdata;
        default: ;
      endcase
    end
  end

  // address decode, tried in the order data, heap, stack, text
  assign heap_live = (heap_top_q > smha_pkg::HEAP_BASE);

  always_comb begin
    hit_data  = smha_pkg::seg_fit(in_q.addr, nm1, {1'b0, data_base_q}, {1'b0, data_last_q},
                                  33'(smha_pkg::DATA_BYTES));
    hit_heap  = smha_pkg::seg_fit(in_q.addr, nm1, {1'b0, smha_pkg::HEAP_BASE},
                                  {1'b0, heap_top_q} - 33'd1, 33'(smha_pkg::HEAP_BYTES));
    hit_stack = smha_pkg::seg_fit(in_q.addr, nm1, smha_pkg::STACK_LO,
                                  {1'b0, smha_pkg::STACK_TOP}, 33'(smha_pkg::STACK_BYTES));
    hit_text  = smha_pkg::seg_fit(in_q.addr, nm1, {1'b0, text_base_q}, {1'b0, text_last_q},
                                  33'(smha_pkg::TEXT_BYTES));
    dec_ok  = 1'b0;
    dec_seg = smha_pkg::SEG_DATA;
    dec_off = hit_data.off;
    if (hit_data.hit) begin
      dec_ok = hit_data.fit;
    end else if (heap_live && hit_heap.hit) begin
      dec_ok  = hit_heap.fit;
      dec_seg = smha_pkg::SEG_HEAP;
      dec_off = hit_heap.off;
    end else if (hit_stack.hit) begin
      dec_ok  = hit_stack.fit;
      dec_seg = smha_pkg::SEG_STACK;
      dec_off = hit_stack.off;
    end else if (hit_text.hit) begin
      dec_ok  = hit_text.fit;
      dec_seg = smha_pkg::SEG_TEXT;
      dec_off = hit_text.off;
    end
  end

  assign mem_go = exec && ((in_q.kind == smha_pkg::KIND_READ) ||
                           (in_q.kind == smha_pkg::KIND_WRITE)) &&
                  (in_q.access_size != smha_pkg::SIZE_BAD) && dec_ok;

  // byte lanes: lane l holds bytes whose segment offset has low bits l
  always_comb begin
    logic [1:0]                idx;
    logic [smha_pkg::ROW_W-1:0] row;
    for (int l = 0; l < smha_pkg::LANES; l++) begin
      idx = 2'(l) - dec_off[1:0];
      row = dec_off[smha_pkg::OFF_W-1:2] +
            ((2'(l) < dec_off[1:0]) ? smha_pkg::ROW_W'(1) : smha_pkg::ROW_W'(0));
      lane_addr[l]  = {dec_seg, row};
      lane_wdata[l] = 8'(in_q.write_data >> {idx, 3'b000});
      lane_we[l]    = mem_go && (in_q.kind == smha_pkg::KIND_WRITE) && (idx <= nm1);
      lane_re[l]    = mem_go && (in_q.kind == smha_pkg::KIND_READ);
    end
  end

  for (genvar g = 0; g < smha_pkg::LANES; g++) begin : g_lane
    smha_ram #(
      .WIDTH (8),
      .DEPTH (smha_pkg::RAM_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (lane_we[g]),
      .re_i    (lane_re[g]),
      .addr_i  (lane_addr[g]),
      .wdata_i (lane_wdata[g]),
      .rdata_o (lane_rdata[g])
    );
  end

  // heap allocation
  assign aligned  = ({1'b0, heap_top_q} + 33'd3) & ~33'd3;
  assign next_top = {1'b0, aligned} + {2'b00, in_q.alloc_bytes};
  assign alloc_ok = (next_top >= {2'b00, smha_pkg::HEAP_BASE}) &&
                    (next_top < smha_pkg::HEAP_END);

  always_comb begin
    status_d   = status_q;
    grant_d    = grant_q;
    rd_d       = rd_q;
    off_lo_d   = off_lo_q;
    nm1_d      = nm1_q;
    heap_top_d = heap_top_q;
    if (exec) begin
      status_d = smha_pkg::ST_OK;
      grant_d  = 32'd0;
      rd_d     = 1'b0;
      off_lo_d = dec_off[1:0];
      nm1_d    = nm1;
      case (in_q.kind) inside
        smha_pkg::KIND_READ, smha_pkg::KIND_WRITE: begin
          if (in_q.access_size == smha_pkg::SIZE_BAD) begin
            status_d = smha_pkg::ST_SIZE;
          end else if (!dec_ok) begin
            status_d = smha_pkg::ST_RANGE;
          end else begin
            rd_d = (in_q.kind == smha_pkg::KIND_READ);
          end
        end
        smha_pkg::KIND_ALLOC: begin
          if (alloc_ok) begin
            grant_d    = aligned[31:0];
            heap_top_d = next_top[31:0];
          end else begin
            status_d = smha_pkg::ST_FULL;
          end
        end
        default: ;
      endcase
    end
  end

  // gather read bytes back into little-endian order
  always_comb begin
    logic [1:0] ln;
    rd_word = 32'd0;
    for (int i = 0; i < smha_pkg::LANES; i++) begin
      ln = off_lo_q + 2'(i);
      if (2'(i) <= nm1_q) begin
        rd_word[8*i +: 8] = lane_rdata[ln];
      end
    end
  end

  // control
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      smha_pkg::FSM_IDLE: begin
        if (in_valid_i) begin
          state_d = smha_pkg::FSM_EXEC;
        end
      end
      smha_pkg::FSM_EXEC: begin
        state_d = smha_pkg::FSM_FIN;
      end
      smha_pkg::FSM_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d      = 1'b1;
          out_d.read_data  = rd_q ? rd_word : 32'd0;
          out_d.alloc_addr = grant_q;
          out_d.status     = status_q;
          state_d          = smha_pkg::FSM_IDLE;
        end
      end
      default: state_d = smha_pkg::FSM_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == smha_pkg::FSM_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smha_pkg::FSM_IDLE;
      out_valid_q <= 1'b0;
      heap_top_q  <= smha_pkg::HEAP_BASE;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      heap_top_q  <= heap_top_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    out_q    <= out_d;
    status_q <= status_d;
    grant_q  <= grant_d;
    rd_q     <= rd_d;
    off_lo_q <= off_lo_d;
    nm1_q    <= nm1_d;
  end

  a_heap_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (heap_top_q >= smha_pkg::HEAP_BASE) && ({2'b00, heap_top_q} < smha_pkg::HEAP_END))
    else $error("heap top left the heap segment");

  a_write_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lane_we[0] || lane_we[1] || lane_we[2] || lane_we[3]) |-> exec)
    else $error("ram written outside the execute state");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> exec)
    else $error("accepted word did not move to execute");

  a_read_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.read_data != 32'd0)) |->
      ((out_data_o.status == smha_pkg::ST_OK) && (out_data_o.alloc_addr == 32'd0)))
    else $error("read data on a failed or allocation result");

endmodule

// ----- rtl/smha_ram.sv -----
// generic single-port ram with registered read
module smha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the segmented memory with heap allocator
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  KIND_NONE   = 2'd3;
  localparam logic [1:0]  SZ_BYTE     = 2'd0;
  localparam logic [1:0]  SZ_HALF     = 2'd1;
  localparam logic [1:0]  SZ_WORD     = 2'd2;
  localparam logic [31:0] STACK_FLOOR = smha_pkg::STACK_TOP - smha_pkg::STACK_BYTES + 1;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  smha_pkg::in_t               in_data_i   = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  smha_pkg::out_t              out_data_o;
  logic                        psel        = 1'b0;
  logic                        penable     = 1'b0;
  logic                        pwrite      = 1'b0;
  logic [smha_pkg::CFG_AW-1:0] paddr       = '0;
  logic [31:0]                 pwdata      = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  logic [31:0] seg_cfg [4] = '{smha_pkg::TEXT_BASE_RST, smha_pkg::TEXT_LAST_RST,
                               smha_pkg::DATA_BASE_RST, smha_pkg::DATA_LAST_RST};
  string       reg_name [4] = '{"text_base", "text_last", "data_base", "data_last"};
  logic [31:0] heap_top_q = smha_pkg::HEAP_BASE;
  logic [7:0]  shadow_bytes [4][65536];
  bit          shadow_valid [4][65536];
  logic [31:0] touched [$];
  smha_pkg::out_t results_due [$];

  int mismatches = 0;
  int n_reads    = 0;
  int n_writes   = 0;
  int n_allocs   = 0;
  int n_layouts  = 0;
  int burst_left = 0;
  int sink_cycle = 0;
  int sink_mode  = 0;
  bit full_rate  = 1'b0;

  segmented_memory_with_heap_alloc u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic bit seg_span(input logic [31:0] a, input int unsigned n,
                                  input logic [32:0] lo, input logic [32:0] hi,
                                  input int unsigned bytes, output bit hit,
                                  output int unsigned off);
    logic [33:0] hi_c;
    hi_c = {1'b0, lo} + 34'(bytes) - 34'd1;
    if ({1'b0, hi} < hi_c) hi_c = {1'b0, hi};
    hit = (hi >= lo) && ({1'b0, a} >= lo) && ({2'b00, a} <= hi_c);
    off = a - lo[31:0];
    return hit && ({2'b00, a} + 34'(n) - 34'd1 <= hi_c);
  endfunction

  function automatic bit locate(input logic [31:0] a, input int unsigned n,
                                output logic [1:0] seg, output int unsigned off);
    bit hit;
    bit fit;
    seg = smha_pkg::SEG_DATA;
    fit = seg_span(a, n, {1'b0, seg_cfg[smha_pkg::REG_DATA_BASE]},
                   {1'b0, seg_cfg[smha_pkg::REG_DATA_LAST]}, smha_pkg::DATA_BYTES, hit, off);
    if (hit) return fit;
    if (heap_top_q > smha_pkg::HEAP_BASE) begin
      seg = smha_pkg::SEG_HEAP;
      fit = seg_span(a, n, {1'b0, smha_pkg::HEAP_BASE}, {1'b0, heap_top_q} - 33'd1,
                     smha_pkg::HEAP_BYTES, hit, off);
      if (hit) return fit;
    end
    seg = smha_pkg::SEG_STACK;
    fit = seg_span(a, n, {1'b0, STACK_FLOOR}, {1'b0, smha_pkg::STACK_TOP},
                   smha_pkg::STACK_BYTES, hit, off);
    if (hit) return fit;
    seg = smha_pkg::SEG_TEXT;
    fit = seg_span(a, n, {1'b0, seg_cfg[smha_pkg::REG_TEXT_BASE]},
                   {1'b0, seg_cfg[smha_pkg::REG_TEXT_LAST]}, smha_pkg::TEXT_BYTES, hit, off);
    if (hit) return fit;
    return 1'b0;
  endfunction

  function automatic smha_pkg::out_t apply_memory_op(input smha_pkg::in_t w);
    smha_pkg::out_t r;
    logic [1:0]     seg;
    int unsigned    off;
    int unsigned    nbytes;
    logic [33:0]    aligned;
    logic [33:0]    next_top;
    r = '0;
    if (w.kind == smha_pkg::KIND_READ || w.kind == smha_pkg::KIND_WRITE) begin
      if (w.kind == smha_pkg::KIND_READ) n_reads++;
      else n_writes++;
      if (w.access_size == smha_pkg::SIZE_BAD) begin
        r.status = smha_pkg::ST_SIZE;
      end else begin
        nbytes = 1 << w.access_size;
        if (!locate(w.addr, nbytes, seg, off)) begin
          r.status = smha_pkg::ST_RANGE;
        end else if (w.kind == smha_pkg::KIND_READ) begin
          for (int i = 0; i < nbytes; i++) r.read_data[8*i +: 8] = shadow_bytes[seg][off + i];
        end else begin
          for (int i = 0; i < nbytes; i++) begin
            shadow_bytes[seg][off + i] = w.write_data[8*i +: 8];
            shadow_valid[seg][off + i] = 1'b1;
          end
          touched.push_back(w.addr);
          if (touched.size() > 64) void'(touched.pop_front());
        end
      end
    end else if (w.kind == smha_pkg::KIND_ALLOC) begin
      n_allocs++;
      aligned  = ({2'b00, heap_top_q} + 34'd3) & ~34'd3;
      next_top = aligned + {2'b00, w.alloc_bytes};
      if (next_top - {2'b00, smha_pkg::HEAP_BASE} < 34'(smha_pkg::HEAP_BYTES)) begin
        r.alloc_addr = aligned[31:0];
        heap_top_q   = next_top[31:0];
      end else begin
        r.status = smha_pkg::ST_FULL;
      end
    end
    return r;
  endfunction

  function automatic smha_pkg::in_t access_word(input logic [1:0] k, input logic [1:0] s,
                                                input logic [31:0] a, input logic [31:0] d);
    return '{kind: k, access_size: s, addr: a, write_data: d, alloc_bytes: $urandom};
  endfunction

  function automatic smha_pkg::in_t alloc_word(input logic [31:0] bytes);
    return '{kind: smha_pkg::KIND_ALLOC, access_size: 2'($urandom), addr: $urandom,
             write_data: $urandom, alloc_bytes: bytes};
  endfunction

  function automatic logic [31:0] pick_addr();
    logic [31:0] edges [10];
    logic [31:0] a;
    edges = '{seg_cfg[smha_pkg::REG_DATA_BASE], seg_cfg[smha_pkg::REG_DATA_LAST],
              seg_cfg[smha_pkg::REG_TEXT_BASE], seg_cfg[smha_pkg::REG_TEXT_LAST],
              STACK_FLOOR, smha_pkg::STACK_TOP, smha_pkg::HEAP_BASE, heap_top_q,
              32'h0, 32'hFFFF_FFFF};
    case ($urandom_range(0, 9)) inside
      [0:3]: begin
        if (touched.size() != 0)
          a = touched[$urandom_range(0, touched.size() - 1)] + $urandom_range(0, 6) - 3;
        else
          a = $urandom;
      end
      4: a = seg_cfg[smha_pkg::REG_DATA_BASE] + ($urandom & 32'hFFFF);
      5: a = seg_cfg[smha_pkg::REG_TEXT_BASE] + ($urandom & 32'hFFFF);
      6: a = STACK_FLOOR + ($urandom & 32'hFFFF);
      7: a = smha_pkg::HEAP_BASE +
             $urandom_range(0, heap_top_q - smha_pkg::HEAP_BASE + 4);
      8: a = edges[$urandom_range(0, 9)] - $urandom_range(0, 3);
      default: a = $urandom;
    endcase
    return a;
  endfunction

  task automatic issue_word(input smha_pkg::in_t w);
    results_due.push_back(apply_memory_op(w));
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    if (burst_left > 0) begin
      burst_left--;
    end else if (!full_rate) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    seg_cfg[idx] = value;
  endtask

  task automatic check_registers();
    logic [1:0] idx;
    for (int k = 0; k < 4; k++) begin
      idx = 2'(k);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      if (prdata !== seg_cfg[idx]) begin
        $error("%s: expected %h, got %h", reg_name[idx], seg_cfg[idx], prdata);
        mismatches++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic set_segments(input logic [31:0] t_base, input logic [31:0] t_last,
                              input logic [31:0] d_base, input logic [31:0] d_last);
    wait_quiet();
    apb_write(smha_pkg::REG_TEXT_BASE, t_base);
    apb_write(smha_pkg::REG_TEXT_LAST, t_last);
    apb_write(smha_pkg::REG_DATA_BASE, d_base);
    apb_write(smha_pkg::REG_DATA_LAST, d_last);
    n_layouts++;
    check_registers();
  endtask

  task automatic test_directed();
    logic [1:0]  rd;
    logic [1:0]  wr;
    logic [31:0] hb;
    logic [31:0] st;
    logic [31:0] tl;
    rd = smha_pkg::KIND_READ;
    wr = smha_pkg::KIND_WRITE;
    hb = smha_pkg::HEAP_BASE;
    st = smha_pkg::STACK_TOP;
    tl = smha_pkg::TEXT_LAST_RST;
    issue_word(access_word(wr, SZ_WORD, 32'h1000_0000, 32'hFFFF_FFFF));
    issue_word(access_word(rd, SZ_WORD, 32'h1000_0000, $urandom));
    issue_word(access_word(wr, SZ_BYTE, 32'h1000_FFFF, 32'h0000_0000));
    issue_word(access_word(rd, SZ_BYTE, 32'h1000_FFFF, $urandom));
    issue_word(access_word(wr, SZ_HALF, 32'h1000_FFFF, $urandom));
    issue_word(access_word(wr, SZ_WORD, 32'h1000_0001, 32'hA5C3_5A3C));
    issue_word(access_word(rd, SZ_HALF, 32'h1000_0003, $urandom));
    issue_word(access_word(rd, SZ_WORD, 32'h1000_0001, $urandom));
    issue_word(access_word(rd, smha_pkg::SIZE_BAD, 32'h1000_0000, $urandom));
    issue_word(access_word(wr, smha_pkg::SIZE_BAD, 32'h1000_0000, $urandom));
    issue_word(access_word(KIND_NONE, SZ_WORD, 32'h1000_0000, $urandom));
    issue_word(access_word(rd, SZ_WORD, 32'h0000_0000, $urandom));
    issue_word(access_word(rd, SZ_WORD, 32'hFFFF_FFFF, $urandom));
    issue_word(access_word(rd, SZ_BYTE, hb, $urandom));
    issue_word(alloc_word(32'd0));
    issue_word(alloc_word(32'd5));
    issue_word(alloc_word(32'd1));
    issue_word(alloc_word(32'hFFFF_FFFF));
    issue_word(access_word(wr, SZ_BYTE, hb + 32'd8, 32'h0000_005A));
    issue_word(access_word(wr, SZ_WORD, hb + 32'd6, $urandom));
    issue_word(access_word(wr, SZ_WORD, st - 32'd3, $urandom));
    issue_word(access_word(rd, SZ_WORD, st - 32'd3, $urandom));
    issue_word(access_word(wr, SZ_HALF, st, $urandom));
    issue_word(access_word(wr, SZ_WORD, tl - 32'd3, $urandom));
    issue_word(access_word(rd, SZ_HALF, tl - 32'd1, $urandom));
  endtask

  task automatic test_random_traffic(input int count);
    smha_pkg::in_t w;
    int            sel;
    logic [1:0]    seg;
    int unsigned   off;
    logic [31:0]   a;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      if (sel < 38) begin
        w = access_word(smha_pkg::KIND_WRITE, 2'($urandom_range(0, 2)), pick_addr(),
                        $urandom);
      end else if (sel < 76) begin
        if (touched.size() != 0 && $urandom_range(0, 2) != 0)
          a = touched[$urandom_range(0, touched.size() - 1)];
        else
          a = pick_addr();
        w = access_word(smha_pkg::KIND_READ, 2'($urandom_range(0, 2)), a, $urandom);
        if (locate(w.addr, 1 << w.access_size, seg, off)) begin
          for (int i = 0; i < (1 << w.access_size); i++)
            if (!shadow_valid[seg][off + i]) w.kind = smha_pkg::KIND_WRITE;
        end
      end else if (sel < 90) begin
        w = alloc_word(($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 64));
      end else if (sel < 96) begin
        w = access_word(($urandom_range(0, 1) != 0) ? smha_pkg::KIND_WRITE
                                                     : smha_pkg::KIND_READ,
                        smha_pkg::SIZE_BAD, pick_addr(), $urandom);
      end else begin
        w = access_word(KIND_NONE, 2'($urandom), $urandom, $urandom);
      end
      issue_word(w);
    end
  endtask

  task automatic test_full_rate(input int count);
    full_rate = 1'b1;
    test_random_traffic(count);
    full_rate = 1'b0;
  endtask

  task automatic test_layouts();
    logic [31:0] layouts [5][4];
    layouts = '{
      '{32'h0000_0000, 32'hFFFF_FFFF, 32'h1003_FF00, 32'h1004_00FF},
      '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FF00, 32'hFFFF_FFFF},
      '{32'h7FFF_8000, 32'h8000_FFFF, 32'h2000_0000, 32'h1FFF_FFFF},
      '{32'h0040_0000, 32'h0040_0003, 32'h0000_0000, 32'hFFFF_FFFF},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1000_0000, 32'h1000_0000}
    };
    for (int k = 0; k < 5; k++) begin
      set_segments(layouts[k][0], layouts[k][1], layouts[k][2], layouts[k][3]);
      test_random_traffic(220);
    end
  endtask

  task automatic test_heap_exhaustion();
    logic [31:0] aligned;
    logic [31:0] heap_end;
    set_segments(smha_pkg::TEXT_BASE_RST, smha_pkg::TEXT_LAST_RST, smha_pkg::DATA_BASE_RST,
                 smha_pkg::DATA_LAST_RST);
    heap_end = smha_pkg::HEAP_BASE + smha_pkg::HEAP_BYTES;
    aligned  = (heap_top_q + 32'd3) & ~32'd3;
    if (aligned <= heap_end - 1)
      issue_word(alloc_word(heap_end - 1 - aligned));
    issue_word(alloc_word(32'd0));
    issue_word(alloc_word(32'd1));
    issue_word(access_word(smha_pkg::KIND_WRITE, SZ_WORD, heap_end - 4, $urandom));
    issue_word(access_word(smha_pkg::KIND_WRITE, SZ_HALF, heap_end - 3, $urandom));
    issue_word(access_word(smha_pkg::KIND_READ,  SZ_HALF, heap_end - 3, $urandom));
    issue_word(access_word(smha_pkg::KIND_READ,  SZ_BYTE, heap_end - 1, $urandom));
    test_random_traffic(150);
  endtask

  always @(posedge clk_i) begin : sink_stall
    logic ready_next;
    sink_cycle++;
    if (sink_cycle % 300 == 0) sink_mode = $urandom_range(0, 3);
    case (full_rate ? 0 : sink_mode)
      0: ready_next = 1'b1;
      1: ready_next = ($urandom_range(0, 1) != 0);
      2: ready_next = ($urandom_range(0, 3) == 0);
      default: ready_next = ((sink_cycle % 7) < 4);
    endcase
    out_ready_i <= ready_next;
  end

  always @(posedge clk_i) begin : result_check
    smha_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (results_due.size() == 0) begin
        $error("result word with none outstanding: %h", out_data_o);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (out_data_o.read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, out_data_o.read_data);
          mismatches++;
        end
        if (out_data_o.alloc_addr !== want.alloc_addr) begin
          $error("alloc_addr: expected %h, got %h", want.alloc_addr, out_data_o.alloc_addr);
          mismatches++;
        end
        if (out_data_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data_o.status);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_registers();
    test_directed();
    test_random_traffic(300);
    test_full_rate(200);
    test_layouts();
    test_heap_exhaustion();
    wait_quiet();
    $display("covered %0d reads, %0d writes and %0d heap allocations", n_reads, n_writes,
             n_allocs);
    $display("over %0d segment layouts, with bursty sends and receiver stalls", n_layouts);
    if (mismatches == 0) begin
      $display("segmented_memory_with_heap_alloc verification clean");
    end else begin
      $display("segmented_memory_with_heap_alloc verification failed");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("segmented_memory_with_heap_alloc verification failed");
    $finish;
  end

endmodule
